### rtl/pdxe_pkg.sv
// Shared types, character codes and escape helpers for the XML escape unit.
// No dependencies; every other file refers to this package by scoped names.
package pdxe_pkg;

  localparam int CntW = 3;  // enough for the longest expansion of one item (7 bytes)

  localparam logic [7:0] CH_PCT  = 8'h25;  // '%'
  localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT   = 8'h3E;  // '>'
  localparam logic [7:0] CH_AMP  = 8'h26;  // '&'
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'

  // Held-sequence state codes.
  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_PCT   = 2'd1;
  localparam logic [1:0] HELD_DIGIT = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } pdxe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } pdxe_out_t;

  // Output plan of one item: literal prefix, one escaped byte, literal suffix.
  typedef struct packed {
    logic [1:0]      pre_cnt;
    logic [7:0]      pre_digit;
    logic [CntW-1:0] esc_len;
    logic [7:0]      esc_byte;
    logic [1:0]      suf_cnt;
    logic [7:0]      suf_digit;
    logic [CntW-1:0] total;
    logic            last;
  } pdxe_plan_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
    end else if (c >= "A" && c <= "F") begin
      v = c - "A" + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      v = c - "a" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic [CntW-1:0] esc_len_of(input logic [7:0] v);
    logic [CntW-1:0] n;
    unique case (v)
      CH_LT, CH_GT:    n = CntW'(4);
      CH_AMP, CH_NUL:  n = CntW'(5);
      default:         n = CntW'(1);
    endcase
    return n;
  endfunction

  // Byte j of the escaped form of v.
  function automatic logic [7:0] esc_char(input logic [7:0] v, input logic [CntW-1:0] j);
    logic [7:0] c;
    c = v;
    unique case (v)
      CH_LT: begin
        unique case (j)
          3'd0:    c = CH_AMP;
          3'd1:    c = "l";
          3'd2:    c = "t";
          default: c = CH_SEMI;
        endcase
      end
      CH_GT: begin
        unique case (j)
          3'd0:    c = CH_AMP;
          3'd1:    c = "g";
          3'd2:    c = "t";
          default: c = CH_SEMI;
        endcase
      end
      CH_AMP: begin
        unique case (j)
          3'd0:    c = CH_AMP;
          3'd1:    c = "a";
          3'd2:    c = "m";
          3'd3:    c = "p";
          default: c = CH_SEMI;
        endcase
      end
      CH_NUL: begin
        unique case (j)
          3'd0:    c = CH_AMP;
          3'd1:    c = "#";
          3'd2:    c = "0";
          3'd3:    c = "0";
          default: c = CH_SEMI;
        endcase
      end
      default: c = v;
    endcase
    return c;
  endfunction

endpackage

### rtl/pdxe_decode.sv
// Percent-sequence tracker: holds the pending '%' and digit and turns each item
// into an output plan. Depends on pdxe_pkg.
module pdxe_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                decode_on,
  input  pdxe_pkg::pdxe_in_t  item,
  output pdxe_pkg::pdxe_plan_t plan
);

  logic [1:0] held_count_r, held_count_nxt;
  logic [7:0] held_digit_r, held_digit_nxt;

  logic [1:0] hc;
  logic [1:0] new_hc;
  logic [1:0] pre_cnt;
  logic [1:0] suf_cnt;
  logic       esc_en;
  logic [7:0] esc_v;
  logic [7:0] b;
  logic       b_hex;
  logic [3:0] hi;
  logic [pdxe_pkg::CntW-1:0] esc_len;
  logic [pdxe_pkg::CntW:0]   sum;

  assign b     = item.in_byte;
  assign b_hex = pdxe_pkg::is_hex(b);
  // A held digit is always a hex digit, so the zero fallback never applies.
  assign hi    = pdxe_pkg::is_hex(held_digit_r) ? pdxe_pkg::hex_val(held_digit_r) : 4'd0;
  // A count of three cannot occur and behaves like a held digit.
  assign hc    = held_count_r[1] ? pdxe_pkg::HELD_DIGIT : held_count_r;

  always_comb begin
    pre_cnt        = 2'd0;
    esc_en         = 1'b0;
    esc_v          = b;
    new_hc         = pdxe_pkg::HELD_NONE;
    held_digit_nxt = held_digit_r;
    if (!decode_on) begin
      pre_cnt = hc;
      esc_en  = 1'b1;
    end else begin
      unique case (hc)
        pdxe_pkg::HELD_NONE: begin
          if (b == pdxe_pkg::CH_PCT) new_hc = pdxe_pkg::HELD_PCT;
          else                       esc_en = 1'b1;
        end
        pdxe_pkg::HELD_PCT: begin
          if (b_hex) begin
            new_hc         = pdxe_pkg::HELD_DIGIT;
            held_digit_nxt = b;
          end else begin
            pre_cnt = 2'd1;
            if (b == pdxe_pkg::CH_PCT) new_hc = pdxe_pkg::HELD_PCT;
            else                       esc_en = 1'b1;
          end
        end
        default: begin
          if (b_hex) begin
            esc_en = 1'b1;
            esc_v  = {hi, pdxe_pkg::hex_val(b)};
          end else begin
            pre_cnt = 2'd2;
            if (b == pdxe_pkg::CH_PCT) new_hc = pdxe_pkg::HELD_PCT;
            else                       esc_en = 1'b1;
          end
        end
      endcase
    end
    // The last byte of a string flushes whatever is still held, after its own output.
    suf_cnt        = item.in_last ? new_hc : 2'd0;
    held_count_nxt = item.in_last ? pdxe_pkg::HELD_NONE : new_hc;
  end

  assign esc_len = esc_en ? pdxe_pkg::esc_len_of(esc_v) : '0;
  assign sum     = {2'b00, pre_cnt} + {1'b0, esc_len} + {2'b00, suf_cnt};

  always_comb begin
    plan.pre_cnt   = pre_cnt;
    plan.pre_digit = held_digit_r;
    plan.esc_len   = esc_len;
    plan.esc_byte  = esc_v;
    plan.suf_cnt   = suf_cnt;
    plan.suf_digit = b;
    plan.total     = sum[pdxe_pkg::CntW-1:0];
    plan.last      = item.in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= pdxe_pkg::HELD_NONE;
    end else if (accept) begin
      held_count_r <= held_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_digit_r <= held_digit_nxt;
    end
  end

endmodule

### rtl/pdxe_emit.sv
// Plan register and output register: walks one item's plan a byte per cycle
// into the result register while the output is not stalled. Depends on pdxe_pkg.
module pdxe_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 plan_load,
  input  pdxe_pkg::pdxe_plan_t plan_in,
  output logic                 item_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pdxe_pkg::pdxe_out_t  out_data
);

  localparam int W = pdxe_pkg::CntW;

  pdxe_pkg::pdxe_plan_t plan_r;
  logic                 plan_valid_r, plan_valid_nxt;
  logic [W-1:0]         idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pdxe_pkg::pdxe_out_t  out_data_r, out_data_nxt;

  logic         out_load;
  logic         is_final;
  logic         plan_done;
  logic [W-1:0] pre_w;
  logic [W-1:0] j;
  logic [W-1:0] m;
  logic [7:0]   cur_byte;

  assign out_load  = plan_valid_r && (!out_valid_r || !out_stall);
  assign is_final  = (idx_r == plan_r.total - W'(1));
  assign plan_done = out_load && is_final;
  // A new item may enter in the same cycle the current plan sends its last byte.
  assign item_stall = plan_valid_r && !plan_done;

  assign pre_w = {{(W-2){1'b0}}, plan_r.pre_cnt};
  assign j     = idx_r - pre_w;
  assign m     = j - plan_r.esc_len;

  always_comb begin
    if (idx_r < pre_w) begin
      cur_byte = (idx_r == '0) ? pdxe_pkg::CH_PCT : plan_r.pre_digit;
    end else if (j < plan_r.esc_len) begin
      cur_byte = pdxe_pkg::esc_char(plan_r.esc_byte, j);
    end else begin
      cur_byte = (m == '0) ? pdxe_pkg::CH_PCT : plan_r.suf_digit;
    end
  end

  always_comb begin
    out_data_nxt.out_byte   = cur_byte;
    out_data_nxt.run_last   = is_final;
    out_data_nxt.string_end = is_final && plan_r.last;

    plan_valid_nxt = plan_valid_r;
    if (plan_load)      plan_valid_nxt = 1'b1;
    else if (plan_done) plan_valid_nxt = 1'b0;

    idx_nxt = idx_r;
    if (plan_load)     idx_nxt = '0;
    else if (out_load) idx_nxt = idx_r + W'(1);

    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_valid_r <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      plan_valid_r <= plan_valid_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (plan_load) plan_r <= plan_in;
    if (out_load)  out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/percent_decode_xml_escape_unit.sv
// Top level of the XML escape unit with optional percent decoding.
// Depends on pdxe_pkg, pdxe_decode and pdxe_emit.
//
// Each input item yields zero to seven output bytes, one output item per byte,
// and the unit takes an item in the same cycle that the previous item's last
// byte moves into the output register, so items that map to one byte stream
// through at one per cycle while the output is not stalled. An item that
// expands (an escape such as &amp;, or literal '%' and digits released from a
// broken or unfinished sequence) keeps the input stalled until its last byte
// has moved into the output register, since the single output register takes
// one byte per cycle and holds its byte while the output is stalled. An item
// that only extends a pending '%' sequence loads no plan and yields nothing.
// Write cfg_wr_data only while the unit is idle; the percent-sequence state
// is kept across writes.
module percent_decode_xml_escape_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pdxe_pkg::pdxe_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pdxe_pkg::pdxe_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  logic                 decode_on_r;
  logic                 accept;
  pdxe_pkg::pdxe_plan_t plan;
  logic                 plan_load;

  assign accept    = in_valid && !in_stall;
  assign plan_load = accept && (plan.total != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_on_r <= 1'b0;
    end else if (cfg_wr_en) begin
      decode_on_r <= cfg_wr_data;
    end
  end

  pdxe_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .decode_on (decode_on_r),
    .item      (in_data),
    .plan      (plan)
  );

  pdxe_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan_load  (plan_load),
    .plan_in    (plan),
    .item_stall (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### rtl/pdxe_chk.sv
// Port-level checker for the XML escape unit, bound to the top level.
// Depends on pdxe_pkg and percent_decode_xml_escape_unit.
module pdxe_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input pdxe_pkg::pdxe_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input pdxe_pkg::pdxe_out_t out_data,
  input logic                cfg_wr_en,
  input logic                cfg_wr_data
);

  // Coming out of reset nothing is pending on either side.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("output valid or input stalled right after reset");

  // A stalled output item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output item changed");

  // The end of a string is always the end of its item's bytes.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.string_end) |-> out_data.run_last)
    else $error("string_end without run_last");

  // The bytes of one item follow each other with no gap.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.run_last) |=> out_valid)
    else $error("gap inside the bytes of one item");

endmodule

bind percent_decode_xml_escape_unit pdxe_chk u_pdxe_chk (.*);

### verif/tb_percent_decode_xml_escape_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for percent_decode_xml_escape_unit: random and directed bytes,
// with a percent-decode and XML-escape predictor checked against every output byte.
// Depends on pdxe_pkg and the unit's RTL only.
module tb_percent_decode_xml_escape_unit;

  localparam int StallLimit = 2000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  pdxe_pkg::pdxe_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  pdxe_pkg::pdxe_out_t out_data;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;

  percent_decode_xml_escape_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor state: decode enable and the held percent sequence.
  logic       decode_on = 1'b0;
  logic [1:0] held_cnt = pdxe_pkg::HELD_NONE;
  logic [7:0] held_dig = 8'h00;
  logic [7:0] run_bytes[$];

  pdxe_pkg::pdxe_in_t  raw_items_q[$];
  pdxe_pkg::pdxe_out_t escaped_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int items_in = 0;
  int bad_count = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  function automatic void emit_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      run_bytes.push_back(s[i]);
    end
  endfunction

  function automatic void emit_escaped(input logic [7:0] c);
    if (c == pdxe_pkg::CH_LT) begin
      emit_text("&lt;");
    end else if (c == pdxe_pkg::CH_GT) begin
      emit_text("&gt;");
    end else if (c == pdxe_pkg::CH_AMP) begin
      emit_text("&amp;");
    end else if (c == pdxe_pkg::CH_NUL) begin
      emit_text("&#00;");
    end else begin
      run_bytes.push_back(c);
    end
  endfunction

  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return 10 + int'(c) - int'("A");
    if (c >= "a" && c <= "f") return 10 + int'(c) - int'("a");
    return -1;
  endfunction

  function automatic void flush_held();
    if (held_cnt != pdxe_pkg::HELD_NONE) run_bytes.push_back(pdxe_pkg::CH_PCT);
    if (held_cnt != pdxe_pkg::HELD_NONE && held_cnt != pdxe_pkg::HELD_PCT) begin
      emit_escaped(held_dig);
    end
    held_cnt = pdxe_pkg::HELD_NONE;
    held_dig = 8'h00;
  endfunction

  // A byte that breaks a sequence releases the held bytes and is then looked at again.
  function automatic void decode_byte(input logic [7:0] b);
    logic finished;
    int   lo;
    int   hi;
    finished = 1'b0;
    while (!finished) begin
      if (held_cnt == pdxe_pkg::HELD_NONE) begin
        if (b == pdxe_pkg::CH_PCT) held_cnt = pdxe_pkg::HELD_PCT;
        else emit_escaped(b);
        finished = 1'b1;
      end else if (held_cnt == pdxe_pkg::HELD_PCT) begin
        if (hex_digit_value(b) >= 0) begin
          held_dig = b;
          held_cnt = pdxe_pkg::HELD_DIGIT;
          finished = 1'b1;
        end else begin
          flush_held();
        end
      end else begin
        lo = hex_digit_value(b);
        if (lo >= 0) begin
          hi = hex_digit_value(held_dig);
          if (hi < 0) hi = 0;
          emit_escaped(8'(hi * 16 + lo));
          held_cnt = pdxe_pkg::HELD_NONE;
          held_dig = 8'h00;
          finished = 1'b1;
        end else begin
          flush_held();
        end
      end
    end
  endfunction

  function automatic void escape_item(input pdxe_pkg::pdxe_in_t it);
    pdxe_pkg::pdxe_out_t r;
    run_bytes.delete();
    if (decode_on) begin
      decode_byte(it.in_byte);
    end else begin
      flush_held();
      emit_escaped(it.in_byte);
    end
    if (it.in_last) flush_held();
    foreach (run_bytes[i]) begin
      r.out_byte   = run_bytes[i];
      r.run_last   = (i == run_bytes.size() - 1);
      r.string_end = r.run_last && it.in_last;
      escaped_q.push_back(r);
    end
  endfunction

  // Driver: a new item is offered once the current one is taken or none is up.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        escape_item(in_data);
        items_in <= items_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (raw_items_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_data  <= raw_items_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off early in the run to fill the unit.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_in >= 4) begin
      hold_done <= 1'b1;
      hold_left <= 80;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: every output byte is checked against the oldest prediction.
  always @(posedge clk) begin
    pdxe_pkg::pdxe_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (escaped_q.size() == 0) begin
        if (bad_count < 10) begin
          $display("unexpected output: byte %h run_last %b string_end %b",
                   out_data.out_byte, out_data.run_last, out_data.string_end);
        end
        bad_count++;
      end else begin
        e = escaped_q.pop_front();
        if (out_data.out_byte !== e.out_byte || out_data.run_last !== e.run_last ||
            out_data.string_end !== e.string_end) begin
          if (bad_count < 10) begin
            $display("mismatch: byte %h run_last %b string_end %b, expected %h %b %b",
                     out_data.out_byte, out_data.run_last, out_data.string_end,
                     e.out_byte, e.run_last, e.string_end);
          end
          bad_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic push_raw(input logic [7:0] b, input logic last);
    pdxe_pkg::pdxe_in_t it;
    it.in_byte = b;
    it.in_last = last;
    raw_items_q.push_back(it);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    logic [7:0] c;
    v = $urandom_range(15);
    if (v < 10) c = "0";
    else if ($urandom_range(1) == 1) c = "A";
    else c = "a";
    if (v >= 10) v = v - 10;
    return c + 8'(v);
  endfunction

  function automatic logic rand_last();
    return ($urandom_range(7) == 0);
  endfunction

  // Well-formed escapes with random digits, broken ones, markup bytes and random bytes.
  task automatic add_random(input int n);
    int k;
    int pick;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        push_raw(pdxe_pkg::CH_PCT, rand_last());
        push_raw(rand_hex_char(), rand_last());
        push_raw(rand_hex_char(), rand_last());
        k += 3;
      end else if (pick < 52) begin
        push_raw(pdxe_pkg::CH_PCT, 1'b0);
        k++;
        if ($urandom_range(1) == 1) begin
          push_raw(rand_hex_char(), 1'b0);
          k++;
        end
        push_raw(8'($urandom_range(255)), rand_last());
        k++;
      end else if (pick < 70) begin
        case ($urandom_range(4))
          0: push_raw(pdxe_pkg::CH_LT, rand_last());
          1: push_raw(pdxe_pkg::CH_GT, rand_last());
          2: push_raw(pdxe_pkg::CH_AMP, rand_last());
          3: push_raw(pdxe_pkg::CH_NUL, rand_last());
          default: push_raw(pdxe_pkg::CH_PCT, rand_last());
        endcase
        k++;
      end else begin
        push_raw(8'($urandom_range(255)), rand_last());
        k++;
      end
    end
  endtask

  task automatic wait_drained();
    while (raw_items_q.size() != 0 || in_valid || escaped_q.size() != 0) @(posedge clk);
    // An item that only extends a sequence leaves nothing to wait for, so allow extra cycles.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_decode(input logic v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    decode_on   = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Decoding off from reset: field extremes, markup, a final literal percent, then random.
    push_raw(pdxe_pkg::CH_NUL, 1'b0);
    push_raw(8'hFF, 1'b0);
    push_raw(pdxe_pkg::CH_LT, 1'b0);
    push_raw(pdxe_pkg::CH_GT, 1'b0);
    push_raw(pdxe_pkg::CH_AMP, 1'b0);
    push_raw(pdxe_pkg::CH_PCT, 1'b1);
    add_random(14);
    wait_drained();

    write_decode(1'b1);
    push_raw(pdxe_pkg::CH_PCT, 1'b0); push_raw("3", 1'b0); push_raw("C", 1'b0);
    push_raw(pdxe_pkg::CH_PCT, 1'b0); push_raw("0", 1'b0); push_raw("0", 1'b0);
    push_raw(pdxe_pkg::CH_PCT, 1'b0); push_raw("f", 1'b0); push_raw("F", 1'b0);
    // Percent followed by a non-hex byte.
    push_raw(pdxe_pkg::CH_PCT, 1'b0); push_raw("G", 1'b0);
    // Percent and digit broken by a new percent, which then decodes to an ampersand.
    push_raw(pdxe_pkg::CH_PCT, 1'b0); push_raw("4", 1'b0); push_raw(pdxe_pkg::CH_PCT, 1'b0);
    push_raw("2", 1'b0); push_raw("6", 1'b0);
    // End of string with a held digit, then with a held percent.
    push_raw(pdxe_pkg::CH_PCT, 1'b0); push_raw("7", 1'b1);
    push_raw(pdxe_pkg::CH_PCT, 1'b1);
    // Left held so that the next phase starts with decoding switched off.
    push_raw(pdxe_pkg::CH_PCT, 1'b0); push_raw("4", 1'b0);
    wait_drained();

    write_decode(1'b0);
    idle_pct = 52;
    add_random(22);
    wait_drained();

    write_decode(1'b1);
    idle_pct  = 0;
    stall_pct = 52;
    add_random(24);
    wait_drained();

    write_decode(1'b1);
    idle_pct  = 16;
    stall_pct = 16;
    add_random(24);
    wait_drained();

    write_decode(1'b0);
    idle_pct  = 0;
    stall_pct = 0;
    add_random(8);
    wait_drained();
    repeat (12) @(posedge clk);

    if (bad_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### percent_decode_xml_escape_unit.f
rtl/pdxe_pkg.sv
rtl/pdxe_decode.sv
rtl/pdxe_emit.sv
rtl/percent_decode_xml_escape_unit.sv
rtl/pdxe_chk.sv
verif/tb_percent_decode_xml_escape_unit.sv
